>>> rtl/core/gbt_pkg.sv
// Goal blacklist table: shared types and constants.
// No dependencies; used by every file of the block but gbt_ram.
`default_nettype none

package gbt_pkg;

   localparam int FIELD_W = 32;
   localparam int TOL_W   = 31;
   localparam int CNT_W   = 4;
   localparam int CMD_W   = 2;
   localparam int DIFF_W  = 34;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ABORT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd1;

   localparam logic [TOL_W-1:0] TOL_RESET = 31'd327680;
   localparam logic [CNT_W-1:0] THR_RESET = 4'd3;

   typedef struct packed {
      logic valid;
      logic hit;
      logic pending;
   } match_flags_type;

endpackage

`default_nettype wire

>>> rtl/core/gbt_ram.sv
// Goal blacklist table: simple dual-port RAM, registered read.
// No dependencies.
`default_nettype none

module gbt_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/gbt_match.sv
// Goal blacklist table: two-stage tolerance compare of one stored entry.
// Depends on gbt_pkg.
`default_nettype none

module gbt_match #(
   parameter int CW = 32,
   parameter int AW = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [AW-1:0]            in_idx,
   input  wire logic [CW-1:0]            in_px,
   input  wire logic [CW-1:0]            in_py,
   input  wire logic [gbt_pkg::CNT_W-1:0] in_cnt,
   input  wire logic [CW-1:0]            goal_x,
   input  wire logic [CW-1:0]            goal_y,
   input  wire logic [gbt_pkg::TOL_W-1:0] tol,
   output gbt_pkg::match_flags_type      out_flags,
   output logic      [AW-1:0]            out_idx,
   output logic      [gbt_pkg::CNT_W-1:0] out_cnt
);

   localparam int EXT = gbt_pkg::DIFF_W - CW;

   logic signed [gbt_pkg::DIFF_W-1:0] gx, gy, px, py, tol_ext;
   logic signed [gbt_pkg::DIFF_W-1:0] dxa_ff, dxb_ff, dya_ff, dyb_ff;
   logic signed [gbt_pkg::DIFF_W-1:0] dxa_in, dxb_in, dya_in, dyb_in;
   logic                              s1_valid_ff, out_valid_ff, out_hit_ff, hit_in;
   logic [AW-1:0]                     s1_idx_ff, out_idx_ff;
   logic [gbt_pkg::CNT_W-1:0]         s1_cnt_ff, out_cnt_ff;

   assign gx = {{EXT{goal_x[CW-1]}}, goal_x};
   assign gy = {{EXT{goal_y[CW-1]}}, goal_y};
   assign px = {{EXT{in_px[CW-1]}}, in_px};
   assign py = {{EXT{in_py[CW-1]}}, in_py};
   assign tol_ext = {{(gbt_pkg::DIFF_W - gbt_pkg::TOL_W){1'b0}}, tol};

   assign dxa_in = gx - px;
   assign dxb_in = px - gx;
   assign dya_in = gy - py;
   assign dyb_in = py - gy;

   // |d| < tol  <=>  d < tol and -d < tol
   assign hit_in = (dxa_ff < tol_ext) && (dxb_ff < tol_ext) &&
                   (dya_ff < tol_ext) && (dyb_ff < tol_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_hit_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
         out_hit_ff   <= s1_valid_ff && hit_in;
      end
   end

   always_ff @(posedge clock) begin
      dxa_ff     <= dxa_in;
      dxb_ff     <= dxb_in;
      dya_ff     <= dya_in;
      dyb_ff     <= dyb_in;
      s1_idx_ff  <= in_idx;
      s1_cnt_ff  <= in_cnt;
      out_idx_ff <= s1_idx_ff;
      out_cnt_ff <= s1_cnt_ff;
   end

   assign out_flags.valid   = out_valid_ff;
   assign out_flags.hit     = out_hit_ff;
   assign out_flags.pending = s1_valid_ff | out_valid_ff;
   assign out_idx = out_idx_ff;
   assign out_cnt = out_cnt_ff;

endmodule

`default_nettype wire

>>> rtl/core/goal_blacklist_table.sv
// Goal blacklist table top level: sequencer, entry RAMs, configuration registers.
// Depends on gbt_pkg, gbt_ram, gbt_match.
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays high
// while the table is scanned, one stored entry per cycle, from the oldest entry
// on, until the first match or the end of the filled part. After a match, reads
// run on while the compare pipeline fills; the single RAM read port sets the
// scan rate. The result shows on the rsp_ ports for one cycle with rsp_valid
// and cannot be held off; busy is already low in that cycle. Write the csr_
// registers only while busy is low.

module goal_blacklist_table #(
   parameter int ENTRIES    = 64,
   parameter int COORD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic        [gbt_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic signed [gbt_pkg::FIELD_W-1:0] req_goal_x,
   input  wire logic signed [gbt_pkg::FIELD_W-1:0] req_goal_y,
   output logic                                    busy,
   output logic                                    rsp_valid,
   output logic                                    rsp_on_blacklist,
   output logic                                    rsp_matched,
   output logic             [gbt_pkg::CNT_W-1:0]   rsp_entry_count,
   output logic                                    rsp_table_full,
   input  wire logic                               csr_wr_en,
   input  wire logic        [gbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [gbt_pkg::TOL_W-1:0]   csr_data
);

   localparam int CW = (COORD_BITS < gbt_pkg::FIELD_W) ? COORD_BITS : gbt_pkg::FIELD_W;
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FW = $clog2(ENTRIES + 1);
   localparam int CNT_W = gbt_pkg::CNT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [FW-1:0]               scan_ff, scan_in;
   logic [gbt_pkg::TOL_W-1:0]   tol_ff;
   logic [CNT_W-1:0]            thr_ff;
   logic [gbt_pkg::CMD_W-1:0]   cmd_ff;
   logic [CW-1:0]               goal_x_ff, goal_y_ff;
   logic                        found_ff, found_in;
   logic [AW-1:0]               found_idx_ff;
   logic [CNT_W-1:0]            found_cnt_ff;
   logic                        rd_valid_ff;
   logic [AW-1:0]               rd_idx_ff;

   logic                        accept, issue;
   logic [AW-1:0]               rd_addr;
   logic [2*CW-1:0]             xy_rd_data;
   logic [CNT_W-1:0]            cnt_rd_data;
   gbt_pkg::match_flags_type    mflags;
   logic [AW-1:0]               m_idx;
   logic [CNT_W-1:0]            m_cnt;

   logic                        is_update, room, append, cnt_we, have;
   logic [CNT_W:0]              cnt_p1, thr_w;
   logic [CNT_W-1:0]            new_cnt;
   logic [AW-1:0]               cnt_wr_addr;

   logic                        rsp_valid_ff, rsp_blk_ff, rsp_matched_ff, rsp_full_ff;
   logic [CNT_W-1:0]            rsp_cnt_ff;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign issue   = (state_ff == ST_SCAN) && !found_ff && !mflags.hit && (scan_ff != fill_ff);
   assign rd_addr = scan_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      found_in = found_ff || (mflags.valid && mflags.hit);
      unique case (state_ff)
         ST_IDLE: begin
            scan_in  = '0;
            found_in = 1'b0;
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + FW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !mflags.pending) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result and write-back
   always_comb begin
      is_update = (cmd_ff == gbt_pkg::CMD_ABORT) || (cmd_ff == gbt_pkg::CMD_TIMEOUT);
      room      = (fill_ff < FW'(ENTRIES));
      cnt_p1    = {1'b0, found_cnt_ff} + (CNT_W+1)'(1);
      thr_w     = {1'b0, thr_ff};
      new_cnt   = found_cnt_ff;
      append    = 1'b0;
      cnt_we    = 1'b0;
      have      = 1'b0;
      if (found_ff) begin
         have   = 1'b1;
         cnt_we = is_update;
         if (cmd_ff == gbt_pkg::CMD_ABORT) begin
            new_cnt = (cnt_p1 < thr_w) ? cnt_p1[CNT_W-1:0] : thr_ff;
         end else if (cmd_ff == gbt_pkg::CMD_TIMEOUT) begin
            new_cnt = (found_cnt_ff > thr_ff) ? found_cnt_ff : thr_ff;
         end
      end else if (is_update && room) begin
         have    = 1'b1;
         append  = 1'b1;
         cnt_we  = 1'b1;
         new_cnt = (cmd_ff == gbt_pkg::CMD_ABORT) ? CNT_W'(1) : thr_ff;
      end
      cnt_wr_addr = found_ff ? found_idx_ff : fill_ff[AW-1:0];
      fill_in     = append ? fill_ff + FW'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= gbt_pkg::TOL_RESET;
         thr_ff       <= gbt_pkg::THR_RESET;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= (state_ff == ST_DECIDE);
         if (state_ff == ST_DECIDE) begin
            fill_ff <= fill_in;
         end
         if (csr_wr_en) begin
            priority if (csr_index == gbt_pkg::CSR_TOLERANCE) begin
               tol_ff <= csr_data;
            end else if (csr_index == gbt_pkg::CSR_THRESHOLD) begin
               thr_ff <= csr_data[CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      if (accept) begin
         cmd_ff    <= req_cmd;
         goal_x_ff <= req_goal_x[CW-1:0];
         goal_y_ff <= req_goal_y[CW-1:0];
      end
      if (!found_ff && mflags.valid && mflags.hit) begin
         found_idx_ff <= m_idx;
         found_cnt_ff <= m_cnt;
      end
      if (state_ff == ST_DECIDE) begin
         rsp_blk_ff     <= have && (new_cnt >= thr_ff);
         rsp_matched_ff <= found_ff;
         rsp_cnt_ff     <= have ? new_cnt : '0;
         rsp_full_ff    <= !found_ff && is_update && !room;
      end
   end

   gbt_ram #(.DEPTH(ENTRIES), .WIDTH(2*CW), .AW(AW)) u_xy_ram (
      .clock   (clock),
      .wr_en   ((state_ff == ST_DECIDE) && append),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data ({goal_x_ff, goal_y_ff}),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (xy_rd_data)
   );

   gbt_ram #(.DEPTH(ENTRIES), .WIDTH(CNT_W), .AW(AW)) u_cnt_ram (
      .clock   (clock),
      .wr_en   ((state_ff == ST_DECIDE) && cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (new_cnt),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd_data)
   );

   gbt_match #(.CW(CW), .AW(AW)) u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_idx    (rd_idx_ff),
      .in_px     (xy_rd_data[2*CW-1:CW]),
      .in_py     (xy_rd_data[CW-1:0]),
      .in_cnt    (cnt_rd_data),
      .goal_x    (goal_x_ff),
      .goal_y    (goal_y_ff),
      .tol       (tol_ff),
      .out_flags (mflags),
      .out_idx   (m_idx),
      .out_cnt   (m_cnt)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_on_blacklist = rsp_blk_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_entry_count  = rsp_cnt_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

`default_nettype wire

>>> rtl/core/gbt_checker.sv
// Goal blacklist table: port-level assertions and their bind to the top level.
// Depends on gbt_pkg and goal_blacklist_table.
`default_nettype none

module gbt_port_assert (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_on_blacklist,
   input wire logic                               rsp_matched,
   input wire logic        [gbt_pkg::CNT_W-1:0]   rsp_entry_count,
   input wire logic                               rsp_table_full
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("request finished without a result");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |->
         (!rsp_matched && !rsp_on_blacklist && (rsp_entry_count == '0)))
      else $error("dropped append reported an entry");

endmodule

bind goal_blacklist_table gbt_port_assert u_gbt_port_assert (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_on_blacklist (rsp_on_blacklist),
   .rsp_matched      (rsp_matched),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_table_full   (rsp_table_full)
);

`default_nettype wire
